>>> hdl/hjc_pkg.sv
// ----------------------------------------------------------------------------
// hjc_pkg
// Types, key codes and jamo tables for the Hangul jamo composer.
// ----------------------------------------------------------------------------
package hjc_pkg;

	localparam logic [15:0] SYL_FIRST   = 16'hAC00;
	localparam logic [15:0] SYL_LAST    = 16'hD7A3;
	localparam logic [15:0] JAMO_FIRST  = 16'h3131;
	localparam logic [15:0] JAMO_LAST   = 16'h3163;
	localparam logic [15:0] VOWEL_FIRST = 16'h314F;
	localparam logic [15:0] CONS_LAST   = 16'h314E;
	localparam logic [15:0] KEY_CR      = 16'h000D;
	localparam logic [15:0] KEY_LF      = 16'h000A;
	localparam logic [15:0] KEY_BS      = 16'h0008;

	localparam int CODE_W = 16;
	localparam int IDX_W  = 5;
	localparam int TDATA_W = 40;

	typedef enum logic [1:0] {
		KIND_COMMIT = 2'd0,
		KIND_DELETE = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	// Index lookup result: ok is low where the table has no entry.
	typedef struct packed {
		logic             ok;
		logic [IDX_W-1:0] idx;
	} jidx_t;

	// Consonant jamo offset (from 0x3131) to initial index.
	function automatic jidx_t cho_of_cons(input logic [IDX_W-1:0] off);
		jidx_t r;
		r.ok = 1'b1;
		unique case (off)
			5'd0:  r.idx = 5'd0;
			5'd1:  r.idx = 5'd1;
			5'd3:  r.idx = 5'd2;
			5'd6:  r.idx = 5'd3;
			5'd7:  r.idx = 5'd4;
			5'd8:  r.idx = 5'd5;
			5'd16: r.idx = 5'd6;
			5'd17: r.idx = 5'd7;
			5'd18: r.idx = 5'd8;
			5'd20: r.idx = 5'd9;
			5'd21: r.idx = 5'd10;
			5'd22: r.idx = 5'd11;
			5'd23: r.idx = 5'd12;
			5'd24: r.idx = 5'd13;
			5'd25: r.idx = 5'd14;
			5'd26: r.idx = 5'd15;
			5'd27: r.idx = 5'd16;
			5'd28: r.idx = 5'd17;
			5'd29: r.idx = 5'd18;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Consonant jamo offset to final index.
	function automatic jidx_t jong_of_cons(input logic [IDX_W-1:0] off);
		jidx_t r;
		r.ok = 1'b1;
		unique case (off)
			5'd0:  r.idx = 5'd1;
			5'd1:  r.idx = 5'd2;
			5'd2:  r.idx = 5'd3;
			5'd3:  r.idx = 5'd4;
			5'd4:  r.idx = 5'd5;
			5'd5:  r.idx = 5'd6;
			5'd6:  r.idx = 5'd7;
			5'd8:  r.idx = 5'd8;
			5'd9:  r.idx = 5'd9;
			5'd10: r.idx = 5'd10;
			5'd11: r.idx = 5'd11;
			5'd12: r.idx = 5'd12;
			5'd13: r.idx = 5'd13;
			5'd14: r.idx = 5'd14;
			5'd15: r.idx = 5'd15;
			5'd16: r.idx = 5'd16;
			5'd17: r.idx = 5'd17;
			5'd19: r.idx = 5'd18;
			5'd20: r.idx = 5'd19;
			5'd21: r.idx = 5'd20;
			5'd22: r.idx = 5'd21;
			5'd23: r.idx = 5'd22;
			5'd25: r.idx = 5'd23;
			5'd26: r.idx = 5'd24;
			5'd27: r.idx = 5'd25;
			5'd28: r.idx = 5'd26;
			5'd29: r.idx = 5'd27;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Final index to consonant jamo offset.
	function automatic logic [IDX_W-1:0] cons_of_jong(input logic [IDX_W-1:0] jong);
		logic [IDX_W-1:0] r;
		unique case (jong)
			5'd1:  r = 5'd0;
			5'd2:  r = 5'd1;
			5'd3:  r = 5'd2;
			5'd4:  r = 5'd3;
			5'd5:  r = 5'd4;
			5'd6:  r = 5'd5;
			5'd7:  r = 5'd6;
			5'd8:  r = 5'd8;
			5'd9:  r = 5'd9;
			5'd10: r = 5'd10;
			5'd11: r = 5'd11;
			5'd12: r = 5'd12;
			5'd13: r = 5'd13;
			5'd14: r = 5'd14;
			5'd15: r = 5'd15;
			5'd16: r = 5'd16;
			5'd17: r = 5'd17;
			5'd18: r = 5'd19;
			5'd19: r = 5'd20;
			5'd20: r = 5'd21;
			5'd21: r = 5'd22;
			5'd22: r = 5'd23;
			5'd23: r = 5'd25;
			5'd24: r = 5'd26;
			5'd25: r = 5'd27;
			5'd26: r = 5'd28;
			5'd27: r = 5'd29;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Initial index to consonant jamo offset.
	function automatic logic [IDX_W-1:0] cons_of_cho(input logic [IDX_W-1:0] cho);
		logic [IDX_W-1:0] r;
		unique case (cho)
			5'd0:  r = 5'd0;
			5'd1:  r = 5'd1;
			5'd2:  r = 5'd3;
			5'd3:  r = 5'd6;
			5'd4:  r = 5'd7;
			5'd5:  r = 5'd8;
			5'd6:  r = 5'd16;
			5'd7:  r = 5'd17;
			5'd8:  r = 5'd18;
			5'd9:  r = 5'd20;
			5'd10: r = 5'd21;
			5'd11: r = 5'd22;
			5'd12: r = 5'd23;
			5'd13: r = 5'd24;
			5'd14: r = 5'd25;
			5'd15: r = 5'd26;
			5'd16: r = 5'd27;
			5'd17: r = 5'd28;
			5'd18: r = 5'd29;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// First part of a compound final, zero for a simple final.
	function automatic logic [IDX_W-1:0] fin_base(input logic [IDX_W-1:0] jong);
		logic [IDX_W-1:0] r;
		unique case (jong)
			5'd3:  r = 5'd1;
			5'd5,
			5'd6:  r = 5'd4;
			5'd9, 5'd10, 5'd11, 5'd12,
			5'd13, 5'd14, 5'd15: r = 5'd8;
			5'd18: r = 5'd17;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Second part of a compound final.
	function automatic logic [IDX_W-1:0] fin_add(input logic [IDX_W-1:0] jong);
		logic [IDX_W-1:0] r;
		unique case (jong)
			5'd3:  r = 5'd19;
			5'd5:  r = 5'd22;
			5'd6:  r = 5'd27;
			5'd9:  r = 5'd1;
			5'd10: r = 5'd16;
			5'd11: r = 5'd17;
			5'd12: r = 5'd19;
			5'd13: r = 5'd25;
			5'd14: r = 5'd26;
			5'd15: r = 5'd27;
			5'd18: r = 5'd19;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Compound final made of a final and one more final, if one exists.
	function automatic jidx_t fin_join(input logic [IDX_W-1:0] jong,
			input logic [IDX_W-1:0] add);
		jidx_t r;
		r.ok = 1'b1;
		unique case ({jong, add})
			{5'd1, 5'd19}:  r.idx = 5'd3;
			{5'd4, 5'd22}:  r.idx = 5'd5;
			{5'd4, 5'd27}:  r.idx = 5'd6;
			{5'd8, 5'd1}:   r.idx = 5'd9;
			{5'd8, 5'd16}:  r.idx = 5'd10;
			{5'd8, 5'd17}:  r.idx = 5'd11;
			{5'd8, 5'd19}:  r.idx = 5'd12;
			{5'd8, 5'd25}:  r.idx = 5'd13;
			{5'd8, 5'd26}:  r.idx = 5'd14;
			{5'd8, 5'd27}:  r.idx = 5'd15;
			{5'd17, 5'd19}: r.idx = 5'd18;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// First vowel of a compound vowel, zero for a simple vowel.
	function automatic logic [IDX_W-1:0] vow_base(input logic [IDX_W-1:0] jung);
		logic [IDX_W-1:0] r;
		unique case (jung)
			5'd9, 5'd10, 5'd11:  r = 5'd8;
			5'd14, 5'd15, 5'd16: r = 5'd13;
			5'd19:               r = 5'd18;
			default:             r = 5'd0;
		endcase
		return r;
	endfunction

	// Second vowel of a compound vowel.
	function automatic logic [IDX_W-1:0] vow_add(input logic [IDX_W-1:0] jung);
		logic [IDX_W-1:0] r;
		unique case (jung)
			5'd10: r = 5'd1;
			5'd11: r = 5'd20;
			5'd14: r = 5'd4;
			5'd15: r = 5'd5;
			5'd16: r = 5'd20;
			5'd19: r = 5'd20;
			default: r = 5'd0;
		endcase
		return r;
	endfunction

	// Compound vowel made of a medial and one more vowel, if one exists.
	function automatic jidx_t vow_join(input logic [IDX_W-1:0] jung,
			input logic [IDX_W-1:0] v);
		jidx_t r;
		r.ok = 1'b1;
		unique case ({jung, v})
			{5'd8, 5'd0}:   r.idx = 5'd9;
			{5'd8, 5'd1}:   r.idx = 5'd10;
			{5'd8, 5'd20}:  r.idx = 5'd11;
			{5'd13, 5'd4}:  r.idx = 5'd14;
			{5'd13, 5'd5}:  r.idx = 5'd15;
			{5'd13, 5'd20}: r.idx = 5'd16;
			{5'd18, 5'd20}: r.idx = 5'd19;
			default: begin
				r.ok  = 1'b0;
				r.idx = 5'd0;
			end
		endcase
		return r;
	endfunction

	// Precomposed syllable code from its three indexes.
	function automatic logic [CODE_W-1:0] syl_code(input logic [IDX_W-1:0] cho,
			input logic [IDX_W-1:0] jung, input logic [IDX_W-1:0] jong);
		return SYL_FIRST + 16'(cho) * 16'd588 + 16'(jung) * 16'd28 + 16'(jong);
	endfunction

endpackage

>>> hdl/hangul_jamo_composer_core.sv
// ----------------------------------------------------------------------------
// hangul_jamo_composer_core
// Two-set Hangul syllable composer: merges key codes into the character
// under composition and streams out commits, deletes and a status per key.
// ----------------------------------------------------------------------------
//
//  channel   dir  handshake              payload
//  s_*       in   s_tvalid / s_tready    s_tdata[15:0] = char_code
//  m_*       out  m_tvalid / m_tready    m_tdata, m_tuser = kind, m_tlast = last
//  cfg_*     in   cfg_valid / cfg_ready  cfg_data = single_line
//
// A key is registered, decoded against the composition state and its
// results (one to four) are loaded into the result register. The result
// register hands out one transfer per cycle while m_tready is high; a key has
// one result for most keys and four for a newline during composition.
// The next key is taken while the last result of the previous one is
// transferred. arst_n clears the composition state and single_line; a stalled
// m_tready holds the current result and backs up into s_tready.
module hangul_jamo_composer_core (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [15:0]          s_tdata,   // [15:0] char_code
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [15:0] out_code, [16] composing_now, [32:17] composing_char, [39:33] zero
	output logic [39:0]          m_tdata,
	output logic [1:0]           m_tuser,   // [1:0] kind
	output logic                 m_tlast,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic                 cfg_data
);
	import hjc_pkg::*;

	// Configuration.
	logic single_line_q;

	// Input register.
	logic              valid_s1;
	logic [CODE_W-1:0] char_s1;

	// Composition state, kept both as indexes and as the code.
	logic              act_q;
	logic              syl_q;
	logic [IDX_W-1:0]  cho_q;
	logic [IDX_W-1:0]  jung_q;
	logic [IDX_W-1:0]  jong_q;
	logic [IDX_W-1:0]  cons_q;
	logic [CODE_W-1:0] code_q;

	// Result register: up to three leading results, then the status.
	logic              valid_s2;
	kind_t             pre_kind_s2 [4];
	logic [CODE_W-1:0] pre_code_s2 [4];
	logic [1:0]        cnt_s2;
	logic              now_s2;
	logic [CODE_W-1:0] char_s2;
	logic [1:0]        idx_q;

	// Decode signals.
	logic              is_nl, is_bs, is_jamo, is_vow;
	logic [CODE_W-1:0] c_off16, v_off16;
	logic [IDX_W-1:0]  coff, voff;
	jidx_t             cj, fj, vj, uc, tc;
	logic [IDX_W-1:0]  jbase, tail_off;
	logic [CODE_W-1:0] rest_code;

	logic              n_act, n_syl;
	logic [IDX_W-1:0]  n_cho, n_jung, n_jong, n_cons;
	logic [CODE_W-1:0] n_code;
	kind_t             n_kind [4];
	logic [CODE_W-1:0] n_pcode [4];
	logic [1:0]        n_cnt;

	logic out_fire, out_end, s2_free, adv;
	kind_t             o_kind;
	logic [CODE_W-1:0] o_code;

	assign cfg_ready = 1'b1;

	assign out_fire = valid_s2 & m_tready;
	assign out_end  = (idx_q == cnt_s2);
	assign s2_free  = !valid_s2 || (out_fire && out_end);
	assign adv      = valid_s1 && s2_free;
	assign s_tready = !valid_s1 || s2_free;

	always_comb begin
		is_nl   = (char_s1 == KEY_CR) || (char_s1 == KEY_LF);
		is_bs   = (char_s1 == KEY_BS);
		is_jamo = (char_s1 >= JAMO_FIRST) && (char_s1 <= JAMO_LAST);
		is_vow  = (char_s1 >= VOWEL_FIRST);
		c_off16 = char_s1 - JAMO_FIRST;
		v_off16 = char_s1 - VOWEL_FIRST;
		coff    = c_off16[IDX_W-1:0];
		voff    = v_off16[IDX_W-1:0];

		cj = jong_of_cons(coff);
		fj = fin_join(jong_q, cj.idx);
		vj = vow_join(jung_q, voff);
		uc = cho_of_cons(cons_q);

		// Splitting the last final off a syllable: what stays and what moves on.
		jbase     = fin_base(jong_q);
		tail_off  = cons_of_jong((jbase != '0) ? fin_add(jong_q) : jong_q);
		tc        = cho_of_cons(tail_off);
		rest_code = code_q - 16'(jong_q) + 16'(jbase);
	end

	always_comb begin
		n_act  = act_q;
		n_syl  = syl_q;
		n_cho  = cho_q;
		n_jung = jung_q;
		n_jong = jong_q;
		n_cons = cons_q;
		n_cnt  = 2'd0;
		for (int i = 0; i < 4; i++) begin
			n_kind[i]  = KIND_COMMIT;
			n_pcode[i] = '0;
		end

		if (is_nl) begin
			if (!single_line_q) begin
				if (act_q) begin
					n_pcode[0] = code_q;
					n_pcode[1] = KEY_CR;
					n_pcode[2] = KEY_LF;
					n_cnt      = 2'd3;
				end else begin
					n_pcode[0] = KEY_CR;
					n_pcode[1] = KEY_LF;
					n_cnt      = 2'd2;
				end
				n_act = 1'b0;
			end
		end else if (is_bs) begin
			if (!act_q) begin
				n_kind[0] = KIND_DELETE;
				n_cnt     = 2'd1;
			end else if (!syl_q) begin
				n_act = 1'b0;
			end else if (jong_q != '0) begin
				n_jong = jbase;
			end else if (vow_base(jung_q) != '0) begin
				n_jung = vow_base(jung_q);
			end else begin
				// A bare initial plus vowel falls back to the consonant jamo.
				n_syl  = 1'b0;
				n_cons = cons_of_cho(cho_q);
			end
		end else if (is_jamo) begin
			if (!act_q) begin
				if (!is_vow) begin
					n_act  = 1'b1;
					n_syl  = 1'b0;
					n_cons = coff;
				end else begin
					n_pcode[0] = char_s1;
					n_cnt      = 2'd1;
				end
			end else if (syl_q) begin
				if (!is_vow) begin
					if (jong_q == '0 && cj.ok) begin
						n_jong = cj.idx;
					end else if (jong_q != '0 && cj.ok && fj.ok) begin
						n_jong = fj.idx;
					end else begin
						n_pcode[0] = code_q;
						n_cnt      = 2'd1;
						n_syl      = 1'b0;
						n_cons     = coff;
					end
				end else if (jong_q == '0 && vj.ok) begin
					n_jung = vj.idx;
				end else if (jong_q != '0) begin
					// The last final consonant starts a new syllable with the vowel.
					n_pcode[0] = rest_code;
					n_cnt      = 2'd1;
					n_cho      = tc.idx;
					n_jung     = voff;
					n_jong     = '0;
				end else begin
					n_pcode[0] = code_q;
					n_pcode[1] = char_s1;
					n_cnt      = 2'd2;
					n_act      = 1'b0;
				end
			end else begin
				if (!is_vow) begin
					n_pcode[0] = code_q;
					n_cnt      = 2'd1;
					n_cons     = coff;
				end else if (uc.ok) begin
					n_syl  = 1'b1;
					n_cho  = uc.idx;
					n_jung = voff;
					n_jong = '0;
				end else begin
					n_pcode[0] = code_q;
					n_pcode[1] = char_s1;
					n_cnt      = 2'd2;
					n_act      = 1'b0;
				end
			end
		end else begin
			if (act_q) begin
				n_pcode[0] = code_q;
				n_pcode[1] = char_s1;
				n_cnt      = 2'd2;
			end else begin
				n_pcode[0] = char_s1;
				n_cnt      = 2'd1;
			end
			n_act = 1'b0;
		end

		if (!n_act) begin
			n_code = '0;
		end else if (n_syl) begin
			n_code = syl_code(n_cho, n_jung, n_jong);
		end else begin
			n_code = JAMO_FIRST + 16'(n_cons);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			single_line_q <= 1'b0;
		end else if (cfg_valid && cfg_ready) begin
			single_line_q <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			char_s1 <= s_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q  <= 1'b0;
			syl_q  <= 1'b0;
			cho_q  <= '0;
			jung_q <= '0;
			jong_q <= '0;
			cons_q <= '0;
			code_q <= '0;
		end else if (adv) begin
			act_q  <= n_act;
			syl_q  <= n_syl;
			cho_q  <= n_cho;
			jung_q <= n_jung;
			jong_q <= n_jong;
			cons_q <= n_cons;
			code_q <= n_code;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
			idx_q    <= 2'd0;
		end else if (s2_free) begin
			valid_s2 <= adv;
			idx_q    <= 2'd0;
		end else if (out_fire) begin
			idx_q <= idx_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			pre_kind_s2 <= n_kind;
			pre_code_s2 <= n_pcode;
			cnt_s2      <= n_cnt;
			now_s2      <= n_act;
			char_s2     <= n_code;
		end
	end

	always_comb begin
		if (idx_q < cnt_s2) begin
			o_kind = pre_kind_s2[idx_q];
			o_code = pre_code_s2[idx_q];
		end else begin
			o_kind = KIND_STATUS;
			o_code = '0;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tuser  = o_kind;
	assign m_tlast  = out_end;
	assign m_tdata  = {(TDATA_W - 2 * CODE_W - 1)'(0), char_s2, now_s2, o_code};

endmodule
